// ----- design/max_heap_priority_queue_assert.svh -----
// assertion macros used by the heap queue checker
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// clocked check, off while reset is asserted
`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mhpq_pkg.sv -----
// types, codes and microcode table of the max heap priority queue
package mhpq_pkg;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] key_in;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] key_out;
        logic [7:0]         fill_count;
    } rsp_t;

    localparam int KEY_W  = 32;
    localparam int STEP_W = 4;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISP = 4'd1;
    localparam logic [STEP_W-1:0] STEP_IN0  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_IN1  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_UP0  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_UP1  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_WRK  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EX0  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EX1  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EX2  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_DN0  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DN1  = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DN0B = 4'd13;
    localparam logic [STEP_W-1:0] STEP_REJF = 4'd14;
    localparam logic [STEP_W-1:0] STEP_REJE = 4'd15;

    typedef enum logic [1:0] {
        RDA_PARENT,
        RDA_ROOT,
        RDA_LEFT
    } rda_sel_t;

    typedef enum logic {
        RDB_LAST,
        RDB_RIGHT
    } rdb_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_KEY
    } wr_sel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_INS_INIT,
        ACT_DEC,
        ACT_LOAD_EX,
        ACT_EMIT_OK,
        ACT_EMIT_FULL,
        ACT_EMIT_EMPTY
    } act_t;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NOSTART,
        COND_OPEXT,
        COND_FULL,
        COND_POSZERO,
        COND_GT,
        COND_EMPTY,
        COND_SETTLED
    } cond_t;

    typedef struct packed {
        rda_sel_t          rda;
        rdb_sel_t          rdb;
        wr_sel_t           wr;
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // control store: a taken condition jumps to target, else fall through
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{rda: RDA_PARENT, rdb: RDB_LAST, wr: WR_NONE, act: ACT_NONE,
              cond: COND_NONE, target: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w.act    = ACT_LATCH;
                w.cond   = COND_NOSTART;
                w.target = STEP_IDLE;
            end
            STEP_DISP:
            begin
                w.cond   = COND_OPEXT;
                w.target = STEP_EX0;
            end
            STEP_IN0:
            begin
                w.cond   = COND_FULL;
                w.target = STEP_REJF;
            end
            STEP_IN1:
            begin
                w.act = ACT_INS_INIT;
            end
            STEP_UP0:
            begin
                w.rda    = RDA_PARENT;
                w.cond   = COND_POSZERO;
                w.target = STEP_WRK;
            end
            STEP_UP1:
            begin
                w.wr     = WR_UP;
                w.cond   = COND_GT;
                w.target = STEP_UP0;
            end
            STEP_WRK:
            begin
                w.wr = WR_KEY;
            end
            STEP_EMIT:
            begin
                w.act    = ACT_EMIT_OK;
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            STEP_EX0:
            begin
                w.cond   = COND_EMPTY;
                w.target = STEP_REJE;
            end
            STEP_EX1:
            begin
                w.rda = RDA_ROOT;
                w.rdb = RDB_LAST;
                w.act = ACT_DEC;
            end
            STEP_EX2:
            begin
                w.act    = ACT_LOAD_EX;
                w.cond   = COND_EMPTY;
                w.target = STEP_EMIT;
            end
            STEP_DN0:
            begin
                w.rda = RDA_LEFT;
                w.rdb = RDB_RIGHT;
            end
            STEP_DN1:
            begin
                w.wr     = WR_DOWN;
                w.cond   = COND_SETTLED;
                w.target = STEP_WRK;
            end
            STEP_DN0B:
            begin
                w.rda    = RDA_LEFT;
                w.rdb    = RDB_RIGHT;
                w.cond   = COND_ALWAYS;
                w.target = STEP_DN1;
            end
            STEP_REJF:
            begin
                w.act    = ACT_EMIT_FULL;
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            STEP_REJE:
            begin
                w.act    = ACT_EMIT_EMPTY;
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/mhpq_ram.sv -----
// generic ram: one write port, two registered read ports
module mhpq_ram
    import mhpq_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/max_heap_priority_queue.sv -----
// binary max heap priority queue with a microcoded sift sequencer
//
// usage
//   a request (req.opcode, req.key_in) is taken at a rising edge with start high
//   and busy low. opcode 0 inserts key_in, opcode 1 extracts the maximum.
//   exactly one result per request: done is high for one cycle with result
//   (status, key_out, fill_count). the receiver cannot stall, so the result
//   must be taken in that cycle; the next request may be issued in it.
// operation
//   insert: the key climbs while it beats its parent, then fills the hole.
//   extract: the root is returned and the last key sinks from the root,
//   unless no other key is left. one request at a time; each heap
//   level costs one ram read step and one compare/write step because the
//   heap ram has a registered read.
// rejects (insert when full, extract when empty) touch no state and return
//   key_out 0 with the matching status.
// reset clears the entry count and the sequencer; ram contents are left as is
//   since only slots below the count are ever read.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t result
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = IDXW + 2;

    // sequencer and datapath registers
    logic [STEP_W-1:0]  upc_reg, upc_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic               op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] out_key_reg, out_key_next;
    logic [IDXW-1:0]    pos_reg, pos_next;
    rsp_t               result_reg, result_next;

    ctrl_word_t ctrl;

    // ram interface
    logic              ram_we;
    logic [IDXW-1:0]   ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [IDXW-1:0]   ram_raddr_a, ram_raddr_b;
    logic [KEY_W-1:0]  ram_rdata_a, ram_rdata_b;
    logic signed [31:0] rd_a, rd_b;

    // address arithmetic
    logic [IDXW-1:0] pos_m1, parent_idx, last_idx, best_idx;
    logic [CW-1:0]   cnt_dec, cnt_inc;
    logic [XW-1:0]   lc_x, rc_x, cnt_x;
    logic [CW+7:0]   cnt_wide;

    // compare results
    logic               gt_a, lc_ok, rc_ok, sel_l, sel_r, moved, cond_hit;
    logic signed [31:0] best_val;

    assign ctrl = ucode_rom(upc_reg);
    assign busy = (upc_reg != STEP_IDLE);
    assign done = done_reg;
    assign result = result_reg;

    assign rd_a = $signed(ram_rdata_a);
    assign rd_b = $signed(ram_rdata_b);

    assign pos_m1     = pos_reg - IDXW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign cnt_dec    = cnt_reg - CW'(1);
    assign cnt_inc    = cnt_reg + CW'(1);
    assign last_idx   = cnt_dec[IDXW-1:0];
    assign lc_x       = {1'b0, pos_reg, 1'b1};
    assign rc_x       = lc_x + XW'(1);
    assign cnt_x      = {{(XW - CW){1'b0}}, cnt_reg};
    assign cnt_wide   = {8'd0, cnt_reg};

    // sift-up: climb while the held key beats its parent
    assign gt_a = key_reg > rd_a;

    // sift-down: larger child wins, left on a tie, only if above the held key
    assign lc_ok    = lc_x < cnt_x;
    assign rc_ok    = rc_x < cnt_x;
    assign sel_l    = lc_ok && (rd_a > key_reg);
    assign sel_r    = rc_ok && (sel_l ? (rd_b > rd_a) : (rd_b > key_reg));
    assign moved    = sel_l || sel_r;
    assign best_val = sel_r ? rd_b : rd_a;
    assign best_idx = sel_r ? rc_x[IDXW-1:0] : lc_x[IDXW-1:0];

    // read address selection
    always_comb
    begin
        case (ctrl.rda)
            RDA_PARENT: ram_raddr_a = parent_idx;
            RDA_ROOT:   ram_raddr_a = '0;
            RDA_LEFT:   ram_raddr_a = lc_x[IDXW-1:0];
            default:    ram_raddr_a = '0;
        endcase
        case (ctrl.rdb)
            RDB_LAST:  ram_raddr_b = last_idx;
            RDB_RIGHT: ram_raddr_b = rc_x[IDXW-1:0];
            default:   ram_raddr_b = last_idx;
        endcase
    end

    // branch condition
    always_comb
    begin
        case (ctrl.cond)
            COND_NONE:    cond_hit = 1'b0;
            COND_ALWAYS:  cond_hit = 1'b1;
            COND_NOSTART: cond_hit = !start;
            COND_OPEXT:   cond_hit = (op_reg == OP_EXTRACT);
            COND_FULL:    cond_hit = (cnt_reg == CW'(CAPACITY));
            COND_POSZERO: cond_hit = (pos_reg == '0);
            COND_GT:      cond_hit = gt_a;
            COND_EMPTY:   cond_hit = (cnt_reg == '0);
            COND_SETTLED: cond_hit = !moved;
            default:      cond_hit = 1'b0;
        endcase
    end

    // datapath actions driven by the control word
    always_comb
    begin
        upc_next     = cond_hit ? ctrl.target : upc_reg + STEP_W'(1);
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        op_next      = op_reg;
        key_next     = key_reg;
        out_key_next = out_key_reg;
        pos_next     = pos_reg;
        result_next  = result_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = key_reg;

        case (ctrl.wr)
            WR_NONE:
            begin
                ram_we = 1'b0;
            end
            WR_UP:
            begin
                // parent drops into the hole, hole moves up
                ram_we    = gt_a;
                ram_wdata = rd_a;
                if (gt_a)
                begin
                    pos_next = parent_idx;
                end
            end
            WR_DOWN:
            begin
                // winning child rises into the hole, hole moves down
                ram_we    = moved;
                ram_wdata = best_val;
                if (moved)
                begin
                    pos_next = best_idx;
                end
            end
            WR_KEY:
            begin
                ram_we    = 1'b1;
                ram_wdata = key_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        case (ctrl.act)
            ACT_NONE:
            begin
                done_next = 1'b0;
            end
            ACT_LATCH:
            begin
                if (start)
                begin
                    op_next      = req.opcode;
                    key_next     = req.key_in;
                    out_key_next = '0;
                end
            end
            ACT_INS_INIT:
            begin
                pos_next = cnt_reg[IDXW-1:0];
                cnt_next = cnt_inc;
            end
            ACT_DEC:
            begin
                cnt_next = cnt_dec;
            end
            ACT_LOAD_EX:
            begin
                out_key_next = rd_a;
                key_next     = rd_b;
                pos_next     = '0;
            end
            ACT_EMIT_OK:
            begin
                done_next   = 1'b1;
                result_next = '{status: STATUS_DONE, key_out: out_key_reg,
                                fill_count: cnt_wide[7:0]};
            end
            ACT_EMIT_FULL:
            begin
                done_next   = 1'b1;
                result_next = '{status: STATUS_FULL, key_out: '0,
                                fill_count: cnt_wide[7:0]};
            end
            ACT_EMIT_EMPTY:
            begin
                done_next   = 1'b1;
                result_next = '{status: STATUS_EMPTY, key_out: '0,
                                fill_count: cnt_wide[7:0]};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= STEP_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        out_key_reg <= out_key_next;
        pos_reg     <= pos_next;
        result_reg  <= result_next;
    end

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

endmodule

// ----- design/mhpq_monitor.sv -----
// port-level checker for the heap queue, bound to the top level
`include "max_heap_priority_queue_assert.svh"

module mhpq_monitor
    import mhpq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t result
);

    // no request completes in the cycle right after it is taken
    `MHPQ_ASSERT(a_no_instant_result, (start && !busy) |=> !done, "result too early")

    // a result only shows while the queue is ready for the next request
    `MHPQ_ASSERT(a_done_not_busy, done |-> !busy, "result while busy")

    // results are single-cycle strobes and never back to back
    `MHPQ_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than a cycle")

    // rejected requests return a zero key
    `MHPQ_ASSERT(a_reject_zero_key,
        (done && (result.status != STATUS_DONE)) |-> (result.key_out == 32'sd0),
        "rejected request returned a key")

    // an empty reject leaves nothing stored
    `MHPQ_ASSERT(a_empty_count,
        (done && (result.status == STATUS_EMPTY)) |-> (result.fill_count == 8'd0),
        "empty status with stored keys")

endmodule

bind max_heap_priority_queue mhpq_monitor u_mhpq_monitor (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);
